// ===== rtl/lrd_pkg.sv =====
`default_nettype none

package lrd_pkg;

    // Field widths
    localparam int CHAR_W   = 8;
    localparam int RUN_W    = 16;
    localparam int SPAN_W   = 16;
    localparam int TOTAL_W  = 32;

    // Width of the column and row counters
    localparam int COORD_BITS = 16;

    // Character codes recognized by the decoder
    localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
    localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_LF     = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;
    localparam logic [CHAR_W-1:0] CH_DEAD   = 8'h62;  // 'b'
    localparam logic [CHAR_W-1:0] CH_DOT    = 8'h2E;  // '.'
    localparam logic [CHAR_W-1:0] CH_LIVE   = 8'h6F;  // 'o'
    localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41; // 'A'
    localparam logic [CHAR_W-1:0] CH_UPPER_Z = 8'h5A; // 'Z'
    localparam logic [CHAR_W-1:0] CH_EOL    = 8'h24;  // '$'
    localparam logic [CHAR_W-1:0] CH_BANG   = 8'h21;  // '!'

    // Result kinds
    typedef enum logic [1:0] {
        KIND_SPAN         = 2'd0,
        KIND_FINISHED     = 2'd1,
        KIND_UNTERMINATED = 2'd2
    } kind_t;

    // One body character
    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              end_of_stream;
    } lrd_req_t;

    // One decoded result
    typedef struct packed {
        kind_t             kind;
        logic [SPAN_W-1:0] span_col;
        logic [SPAN_W-1:0] span_row;
        logic [SPAN_W-1:0] span_len;
        logic              over_limit;
    } lrd_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/lrd_in_reg.sv =====
`default_nettype none

module lrd_in_reg (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              src_valid,
    output logic                   src_stall,
    input  wire lrd_pkg::lrd_req_t src_req,
    output logic                   item_valid,
    output lrd_pkg::lrd_req_t      item_req,
    input  wire logic              item_take
);
    import lrd_pkg::*;

    logic     valid_reg;
    lrd_req_t req_reg;

    // Hold off the source while a registered request is not yet decoded
    assign src_stall  = valid_reg && !item_take;
    assign item_valid = valid_reg;
    assign item_req   = req_reg;

    // Valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!src_stall)
        begin
            valid_reg <= src_valid;
        end
    end

    // Payload capture
    always_ff @(posedge clk)
    begin
        if (src_valid && !src_stall)
        begin
            req_reg <= src_req;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/lrd_core.sv =====
`default_nettype none

module lrd_core (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_we,
    input  wire logic [31:0]               cfg_wdata,
    input  wire logic                      item_valid,
    input  wire lrd_pkg::lrd_req_t         item_req,
    output logic                           item_take,
    output logic                           dst_valid,
    input  wire logic                      dst_stall,
    output lrd_pkg::lrd_rsp_t              dst_req
);
    import lrd_pkg::*;

    localparam int CSUM_W   = ((COORD_BITS > RUN_W) ? COORD_BITS : RUN_W) + 1;
    localparam int PROD_W   = RUN_W + 4;
    localparam logic [COORD_BITS-1:0] COORD_MAX = {COORD_BITS{1'b1}};
    localparam logic [RUN_W-1:0]      RUN_MAX   = {RUN_W{1'b1}};
    localparam logic [TOTAL_W-1:0]    TOTAL_MAX = {TOTAL_W{1'b1}};

    // Saturating position add
    function automatic logic [COORD_BITS-1:0] coord_add(
        input logic [COORD_BITS-1:0] a,
        input logic [RUN_W-1:0]      b
    );
        logic [CSUM_W-1:0] s;
        s = CSUM_W'(a) + CSUM_W'(b);
        if (s > CSUM_W'(COORD_MAX))
        begin
            return COORD_MAX;
        end
        return COORD_BITS'(s);
    endfunction

    // Decoder state
    logic [TOTAL_W-1:0]    cell_limit_reg;
    logic [RUN_W-1:0]      run_acc_reg,   run_acc_next;
    logic [COORD_BITS-1:0] col_pos_reg,   col_pos_next;
    logic [COORD_BITS-1:0] row_pos_reg,   row_pos_next;
    logic [TOTAL_W-1:0]    tag_total_reg, tag_total_next;
    logic                  done_reg,      done_next;

    logic                  out_valid_reg;
    lrd_rsp_t              out_reg;

    // Decode signals
    logic [CHAR_W-1:0]     ch;
    logic                  last;
    logic                  is_space;
    logic                  is_digit;
    logic                  active;
    logic [RUN_W-1:0]      count;
    logic [PROD_W-1:0]     run_prod;
    logic [TOTAL_W:0]      total_sum;
    logic [TOTAL_W-1:0]    total_sat;
    logic                  permitted;
    logic                  finished_now;
    logic                  span_hit;
    logic                  res_valid;
    lrd_rsp_t              res;
    logic                  out_free;

    assign ch   = item_req.char_code;
    assign last = item_req.end_of_stream;

    // Move on whenever the result slot is empty or being drained
    assign out_free  = !out_valid_reg || !dst_stall;
    assign item_take = item_valid && out_free;

    assign dst_valid = out_valid_reg;
    assign dst_req   = out_reg;

    // Character classes
    assign is_space = (ch == CH_SPACE) || (ch == CH_TAB) || (ch == CH_CR) || (ch == CH_LF);
    assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
    assign active   = !done_reg && !is_space;

    // Run count arithmetic: acc * 10 + digit
    assign run_prod  = (PROD_W'(run_acc_reg) << 3) + (PROD_W'(run_acc_reg) << 1)
                     + PROD_W'(ch[3:0]);
    assign count     = (run_acc_reg == '0) ? RUN_W'(1) : run_acc_reg;
    assign total_sum = (TOTAL_W + 1)'(tag_total_reg) + (TOTAL_W + 1)'(count);
    assign total_sat = total_sum[TOTAL_W] ? TOTAL_MAX : total_sum[TOTAL_W-1:0];
    assign permitted = total_sat < cell_limit_reg;

    // Next state and result
    always_comb
    begin
        run_acc_next   = run_acc_reg;
        col_pos_next   = col_pos_reg;
        row_pos_next   = row_pos_reg;
        tag_total_next = tag_total_reg;
        done_next      = done_reg;
        finished_now   = 1'b0;
        span_hit       = 1'b0;

        if (active && is_digit)
        begin
            run_acc_next = (run_prod > PROD_W'(RUN_MAX)) ? RUN_MAX : RUN_W'(run_prod);
        end
        else if (active)
        begin
            run_acc_next   = '0;
            tag_total_next = total_sat;
            if (permitted)
            begin
                if ((ch == CH_DEAD) || (ch == CH_DOT))
                begin
                    col_pos_next = coord_add(col_pos_reg, count);
                end
                else if ((ch == CH_LIVE) || ((ch >= CH_UPPER_A) && (ch <= CH_UPPER_Z)))
                begin
                    span_hit     = 1'b1;
                    col_pos_next = coord_add(col_pos_reg, count);
                end
                else if (ch == CH_EOL)
                begin
                    row_pos_next = coord_add(row_pos_reg, count);
                    col_pos_next = '0;
                end
                else if (ch == CH_BANG)
                begin
                    done_next    = 1'b1;
                    finished_now = 1'b1;
                end
            end
        end

        // Result fields; status results carry zero position and length
        res.over_limit = tag_total_next >= cell_limit_reg;
        res.span_col   = '0;
        res.span_row   = '0;
        res.span_len   = '0;
        if (finished_now)
        begin
            res.kind  = KIND_FINISHED;
            res_valid = 1'b1;
        end
        else if (last)
        begin
            res.kind  = KIND_UNTERMINATED;
            res_valid = !done_reg;
        end
        else
        begin
            res.kind     = KIND_SPAN;
            res.span_col = SPAN_W'(col_pos_reg);
            res.span_row = SPAN_W'(row_pos_reg);
            res.span_len = count;
            res_valid    = span_hit;
        end

        // Last character clears the stream state
        if (last)
        begin
            run_acc_next   = '0;
            col_pos_next   = '0;
            row_pos_next   = '0;
            tag_total_next = '0;
            done_next      = 1'b0;
        end
    end

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_limit_reg <= TOTAL_MAX;
        end
        else if (cfg_we)
        begin
            cell_limit_reg <= cfg_wdata;
        end
    end

    // Stream state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_acc_reg   <= '0;
            col_pos_reg   <= '0;
            row_pos_reg   <= '0;
            tag_total_reg <= '0;
            done_reg      <= 1'b0;
        end
        else if (item_take)
        begin
            run_acc_reg   <= run_acc_next;
            col_pos_reg   <= col_pos_next;
            row_pos_reg   <= row_pos_next;
            tag_total_reg <= tag_total_next;
            done_reg      <= done_next;
        end
    end

    // Result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= item_take && res_valid;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (item_take && res_valid)
        begin
            out_reg <= res;
        end
    end

    // Once finished, no run count is pending
    a_done_no_run: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (run_acc_reg == '0))
        else $error("run count pending after finish");

    // Last character leaves the stream state cleared
    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (item_take && last) |=> (run_acc_reg == '0) && (col_pos_reg == '0)
            && (row_pos_reg == '0) && (tag_total_reg == '0) && !done_reg)
        else $error("state not cleared after last character");

    // Live spans always cover at least one cell
    a_span_len: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_reg.kind == KIND_SPAN)) |-> (out_reg.span_len != '0))
        else $error("empty live span");

    // Status results carry no position or length
    a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_reg.kind != KIND_SPAN)) |-> (out_reg.span_col == '0)
            && (out_reg.span_row == '0) && (out_reg.span_len == '0))
        else $error("status result with span fields");

endmodule

`default_nettype wire

// ===== rtl/life_rle_body_decoder_top.sv =====
`default_nettype none

// Life RLE body decoder. Takes one body character per request on src and
// returns live spans (column, row, length) and end-of-stream status on dst.
// A new character can be taken every cycle while dst does not stall. A
// character's result passes the input register, then one decode step into
// the result register, which presents it on dst. A stalled result holds the
// decode step, and the input register then stalls src. The rate is set by
// the single decode step that updates the run count, position and tag total
// for each character taken. cell_limit is written through cfg_we/cfg_wdata
// and should only change while the block holds no request in flight.
module life_rle_body_decoder_top (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [31:0]           cfg_wdata,
    input  wire logic                  src_valid,
    output logic                       src_stall,
    input  wire lrd_pkg::lrd_req_t     src_req,
    output logic                       dst_valid,
    input  wire logic                  dst_stall,
    output lrd_pkg::lrd_rsp_t          dst_req
);
    import lrd_pkg::*;

    logic     item_valid;
    lrd_req_t item_req;
    logic     item_take;

    // Input register
    lrd_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .src_valid  (src_valid),
        .src_stall  (src_stall),
        .src_req    (src_req),
        .item_valid (item_valid),
        .item_req   (item_req),
        .item_take  (item_take)
    );

    // Decode and result register
    lrd_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .item_valid (item_valid),
        .item_req   (item_req),
        .item_take  (item_take),
        .dst_valid  (dst_valid),
        .dst_stall  (dst_stall),
        .dst_req    (dst_req)
    );

endmodule

`default_nettype wire
